// ===== design/brsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brsc_pkg;

    localparam int unsigned CoordW = 24;    // signed Q15.8 center
    localparam int unsigned HalfW  = 23;    // unsigned Q15.8 half-extent
    localparam int unsigned EdgeW  = CoordW + 1;
    localparam int unsigned DiffW  = EdgeW + 1;
    localparam int unsigned ScaleW = HalfW + 4;
    localparam int unsigned ClassW = 3;
    localparam int unsigned DataW  = 32;
    localparam int unsigned AddrW  = 5;

    // size thresholds: huge / large on the reference side, tiny / small on the object side
    localparam logic [3:0] HUGE_X_MUL   = 4'd10;
    localparam logic [3:0] HUGE_YZ_MUL  = 4'd4;
    localparam logic [3:0] LARGE_X_MUL  = 4'd5;
    localparam logic [3:0] LARGE_YZ_MUL = 4'd2;
    localparam logic [3:0] TINY_X_MUL   = 4'd2;
    localparam logic [3:0] TINY_YZ_MUL  = 4'd5;
    localparam logic [3:0] SMALL_YZ_MUL = 4'd2;

    localparam logic [CoordW-1:0] REF_CENTER_RESET = '0;
    localparam logic [HalfW-1:0]  REF_HALF_RESET   = 23'd256;
    localparam logic [HalfW-1:0]  STUCK_RESET      = 23'd128;
    localparam logic [HalfW-1:0]  FAR_RESET        = 23'd3840;

    typedef enum logic [2:0] {
        REG_REF_CENTER_X = 3'd0,
        REG_REF_CENTER_Y = 3'd1,
        REG_REF_CENTER_Z = 3'd2,
        REG_REF_HALF_X   = 3'd3,
        REG_REF_HALF_Y   = 3'd4,
        REG_REF_HALF_Z   = 3'd5,
        REG_STUCK_LIMIT  = 3'd6,
        REG_FAR_LIMIT    = 3'd7
    } reg_index_t;

    typedef enum logic [ClassW-1:0] {
        REL_INCLUDED   = 3'd0,
        REL_INTERSECTS = 3'd1,
        REL_STUCK      = 3'd2,
        REL_NEAR       = 3'd3,
        REL_FAR        = 3'd4
    } rel_class_t;

    typedef enum logic [ClassW-1:0] {
        SZ_TINY   = 3'd0,
        SZ_SMALL  = 3'd1,
        SZ_NORMAL = 3'd2,
        SZ_LARGE  = 3'd3,
        SZ_HUGE   = 3'd4
    } size_class_t;

    function automatic logic [DiffW-1:0] abs_diff(
        input logic signed [EdgeW-1:0] a,
        input logic signed [EdgeW-1:0] b
    );
        logic signed [DiffW-1:0] d;
        begin
            d = $signed({a[EdgeW-1], a}) - $signed({b[EdgeW-1], b});
            abs_diff = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
        end
    endfunction

    function automatic rel_class_t axis_class(
        input logic signed [CoordW-1:0] oc,
        input logic        [HalfW-1:0]  oh,
        input logic signed [CoordW-1:0] rc,
        input logic        [HalfW-1:0]  rh,
        input logic        [HalfW-1:0]  stuck,
        input logic        [HalfW-1:0]  far_lim
    );
        logic signed [EdgeW-1:0] olo, ohi, rlo, rhi;
        logic signed [EdgeW-1:0] alo, ahi, blo, bhi;
        logic        [DiffW-1:0] g1, g2, gap;
        begin
            olo = $signed({oc[CoordW-1], oc}) - $signed({2'b00, oh});
            ohi = $signed({oc[CoordW-1], oc}) + $signed({2'b00, oh});
            rlo = $signed({rc[CoordW-1], rc}) - $signed({2'b00, rh});
            rhi = $signed({rc[CoordW-1], rc}) + $signed({2'b00, rh});
            g1  = abs_diff(rhi, olo);
            g2  = abs_diff(rlo, ohi);
            gap = (g1 < g2) ? g1 : g2;
            // object first unless the reference starts strictly lower
            if (rlo < olo)
            begin
                alo = rlo; ahi = rhi; blo = olo; bhi = ohi;
            end
            else
            begin
                alo = olo; ahi = ohi; blo = rlo; bhi = rhi;
            end
            if (alo < blo && blo < ahi)
                axis_class = (bhi < ahi) ? REL_INCLUDED : REL_INTERSECTS;
            else if (gap < {3'b000, stuck})
                axis_class = REL_STUCK;
            else if (gap > {3'b000, far_lim})
                axis_class = REL_FAR;
            else
                axis_class = REL_NEAR;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/brsc_obj_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface brsc_obj_if;
    logic                               valid;
    logic                               ready;
    logic signed [brsc_pkg::CoordW-1:0] obj_center_x;
    logic signed [brsc_pkg::CoordW-1:0] obj_center_y;
    logic signed [brsc_pkg::CoordW-1:0] obj_center_z;
    logic        [brsc_pkg::HalfW-1:0]  obj_half_x;
    logic        [brsc_pkg::HalfW-1:0]  obj_half_y;
    logic        [brsc_pkg::HalfW-1:0]  obj_half_z;

    modport source (
        output valid, obj_center_x, obj_center_y, obj_center_z,
               obj_half_x, obj_half_y, obj_half_z,
        input  ready
    );
    modport sink (
        input  valid, obj_center_x, obj_center_y, obj_center_z,
               obj_half_x, obj_half_y, obj_half_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/brsc_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface brsc_res_if;
    logic                             valid;
    logic                             ready;
    logic [brsc_pkg::ClassW-1:0]      relation_class;
    logic [brsc_pkg::ClassW-1:0]      size_class;

    modport source (
        output valid, relation_class, size_class,
        input  ready
    );
    modport sink (
        input  valid, relation_class, size_class,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/box_relation_and_size_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; both stages advance whenever the result is taken.
// The ready chain runs from res.ready back through the two stages in the same cycle.
// Reset (rst_n low, asynchronous): pipeline emptied, reference registers back to
// center 0, half-extent 1.0, stuck limit 0.5, far limit 15.

module box_relation_and_size_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    brsc_obj_if.sink                           obj,
    brsc_res_if.source                         res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [brsc_pkg::AddrW-1:0]    paddr,
    input  wire logic [brsc_pkg::DataW-1:0]    pwdata,
    output logic      [brsc_pkg::DataW-1:0]    prdata,
    output logic                               pready
);

    // configuration registers
    logic signed [brsc_pkg::CoordW-1:0] ref_cx_reg, ref_cy_reg, ref_cz_reg;
    logic        [brsc_pkg::HalfW-1:0]  ref_hx_reg, ref_hy_reg, ref_hz_reg;
    logic        [brsc_pkg::HalfW-1:0]  stuck_reg, far_reg;
    brsc_pkg::reg_index_t               cfg_idx;
    logic                               cfg_wr;

    // stage 1: registered request
    logic                               s1_valid_reg;
    logic signed [brsc_pkg::CoordW-1:0] s1_cx_reg, s1_cy_reg, s1_cz_reg;
    logic        [brsc_pkg::HalfW-1:0]  s1_hx_reg, s1_hy_reg, s1_hz_reg;

    // stage 2: result register
    logic                               res_valid_reg;
    brsc_pkg::rel_class_t               rel_reg, rel_next;
    brsc_pkg::size_class_t              size_reg, size_next;

    logic s2_accept, s1_accept;
    brsc_pkg::rel_class_t c_x, c_y, c_z;
    logic any_far, any_near, any_stuck;
    logic huge, large_sz, tiny, small_sz;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = brsc_pkg::reg_index_t'(paddr[brsc_pkg::AddrW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cx_reg <= brsc_pkg::REF_CENTER_RESET;
            ref_cy_reg <= brsc_pkg::REF_CENTER_RESET;
            ref_cz_reg <= brsc_pkg::REF_CENTER_RESET;
            ref_hx_reg <= brsc_pkg::REF_HALF_RESET;
            ref_hy_reg <= brsc_pkg::REF_HALF_RESET;
            ref_hz_reg <= brsc_pkg::REF_HALF_RESET;
            stuck_reg  <= brsc_pkg::STUCK_RESET;
            far_reg    <= brsc_pkg::FAR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                brsc_pkg::REG_REF_CENTER_X: ref_cx_reg <= pwdata[brsc_pkg::CoordW-1:0];
                brsc_pkg::REG_REF_CENTER_Y: ref_cy_reg <= pwdata[brsc_pkg::CoordW-1:0];
                brsc_pkg::REG_REF_CENTER_Z: ref_cz_reg <= pwdata[brsc_pkg::CoordW-1:0];
                brsc_pkg::REG_REF_HALF_X:   ref_hx_reg <= pwdata[brsc_pkg::HalfW-1:0];
                brsc_pkg::REG_REF_HALF_Y:   ref_hy_reg <= pwdata[brsc_pkg::HalfW-1:0];
                brsc_pkg::REG_REF_HALF_Z:   ref_hz_reg <= pwdata[brsc_pkg::HalfW-1:0];
                brsc_pkg::REG_STUCK_LIMIT:  stuck_reg  <= pwdata[brsc_pkg::HalfW-1:0];
                brsc_pkg::REG_FAR_LIMIT:    far_reg    <= pwdata[brsc_pkg::HalfW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            brsc_pkg::REG_REF_CENTER_X: prdata = brsc_pkg::DataW'(unsigned'(ref_cx_reg));
            brsc_pkg::REG_REF_CENTER_Y: prdata = brsc_pkg::DataW'(unsigned'(ref_cy_reg));
            brsc_pkg::REG_REF_CENTER_Z: prdata = brsc_pkg::DataW'(unsigned'(ref_cz_reg));
            brsc_pkg::REG_REF_HALF_X:   prdata = brsc_pkg::DataW'(ref_hx_reg);
            brsc_pkg::REG_REF_HALF_Y:   prdata = brsc_pkg::DataW'(ref_hy_reg);
            brsc_pkg::REG_REF_HALF_Z:   prdata = brsc_pkg::DataW'(ref_hz_reg);
            brsc_pkg::REG_STUCK_LIMIT:  prdata = brsc_pkg::DataW'(stuck_reg);
            brsc_pkg::REG_FAR_LIMIT:    prdata = brsc_pkg::DataW'(far_reg);
            default:                    prdata = '0;
        endcase
    end

    // pipeline flow
    assign s2_accept = !res_valid_reg || res.ready;
    assign s1_accept = !s1_valid_reg || s2_accept;
    assign obj.ready = s1_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_accept)
                s1_valid_reg <= obj.valid;
            if (s2_accept)
                res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_accept && obj.valid)
        begin
            s1_cx_reg <= obj.obj_center_x;
            s1_cy_reg <= obj.obj_center_y;
            s1_cz_reg <= obj.obj_center_z;
            s1_hx_reg <= obj.obj_half_x;
            s1_hy_reg <= obj.obj_half_y;
            s1_hz_reg <= obj.obj_half_z;
        end
        if (s2_accept && s1_valid_reg)
        begin
            rel_reg  <= rel_next;
            size_reg <= size_next;
        end
    end

    // relation
    always_comb
    begin
        c_x = brsc_pkg::axis_class(s1_cx_reg, s1_hx_reg, ref_cx_reg, ref_hx_reg,
                                   stuck_reg, far_reg);
        c_y = brsc_pkg::axis_class(s1_cy_reg, s1_hy_reg, ref_cy_reg, ref_hy_reg,
                                   stuck_reg, far_reg);
        c_z = brsc_pkg::axis_class(s1_cz_reg, s1_hz_reg, ref_cz_reg, ref_hz_reg,
                                   stuck_reg, far_reg);
        any_far   = (c_x == brsc_pkg::REL_FAR)   || (c_y == brsc_pkg::REL_FAR)
                 || (c_z == brsc_pkg::REL_FAR);
        any_near  = (c_x == brsc_pkg::REL_NEAR)  || (c_y == brsc_pkg::REL_NEAR)
                 || (c_z == brsc_pkg::REL_NEAR);
        any_stuck = (c_x == brsc_pkg::REL_STUCK) || (c_y == brsc_pkg::REL_STUCK)
                 || (c_z == brsc_pkg::REL_STUCK);
        if (c_x == brsc_pkg::REL_INCLUDED && c_y == brsc_pkg::REL_INCLUDED
            && c_z == brsc_pkg::REL_INCLUDED)
            rel_next = brsc_pkg::REL_INCLUDED;
        else if (any_far)
            rel_next = brsc_pkg::REL_FAR;
        else if (any_near)
            rel_next = brsc_pkg::REL_NEAR;
        else if (any_stuck)
            rel_next = brsc_pkg::REL_STUCK;
        else
            rel_next = brsc_pkg::REL_INTERSECTS;
    end

    // size: constant-factor cross-multiplies at ScaleW bits; the small x check compares at HalfW
    always_comb
    begin
        huge = (brsc_pkg::ScaleW'(s1_hx_reg)
                    > brsc_pkg::ScaleW'(ref_hx_reg) * brsc_pkg::ScaleW'(brsc_pkg::HUGE_X_MUL))
            && (brsc_pkg::ScaleW'(s1_hy_reg)
                    > brsc_pkg::ScaleW'(ref_hy_reg) * brsc_pkg::ScaleW'(brsc_pkg::HUGE_YZ_MUL))
            && (brsc_pkg::ScaleW'(s1_hz_reg)
                    > brsc_pkg::ScaleW'(ref_hz_reg) * brsc_pkg::ScaleW'(brsc_pkg::HUGE_YZ_MUL));
        large_sz = (brsc_pkg::ScaleW'(s1_hx_reg)
                    > brsc_pkg::ScaleW'(ref_hx_reg) * brsc_pkg::ScaleW'(brsc_pkg::LARGE_X_MUL))
            && (brsc_pkg::ScaleW'(s1_hy_reg)
                    > brsc_pkg::ScaleW'(ref_hy_reg) * brsc_pkg::ScaleW'(brsc_pkg::LARGE_YZ_MUL))
            && (brsc_pkg::ScaleW'(s1_hz_reg)
                    > brsc_pkg::ScaleW'(ref_hz_reg) * brsc_pkg::ScaleW'(brsc_pkg::LARGE_YZ_MUL));
        tiny = (brsc_pkg::ScaleW'(s1_hx_reg) * brsc_pkg::ScaleW'(brsc_pkg::TINY_X_MUL)
                    < brsc_pkg::ScaleW'(ref_hx_reg))
            && (brsc_pkg::ScaleW'(s1_hy_reg) * brsc_pkg::ScaleW'(brsc_pkg::TINY_YZ_MUL)
                    < brsc_pkg::ScaleW'(ref_hy_reg))
            && (brsc_pkg::ScaleW'(s1_hz_reg) * brsc_pkg::ScaleW'(brsc_pkg::TINY_YZ_MUL)
                    < brsc_pkg::ScaleW'(ref_hz_reg));
        small_sz = (s1_hx_reg < ref_hx_reg)
            && (brsc_pkg::ScaleW'(s1_hy_reg) * brsc_pkg::ScaleW'(brsc_pkg::SMALL_YZ_MUL)
                    < brsc_pkg::ScaleW'(ref_hy_reg))
            && (brsc_pkg::ScaleW'(s1_hz_reg) * brsc_pkg::ScaleW'(brsc_pkg::SMALL_YZ_MUL)
                    < brsc_pkg::ScaleW'(ref_hz_reg));
        // tiny is a subset of small, so it has to be checked first
        if (huge)
            size_next = brsc_pkg::SZ_HUGE;
        else if (large_sz)
            size_next = brsc_pkg::SZ_LARGE;
        else if (tiny)
            size_next = brsc_pkg::SZ_TINY;
        else if (small_sz)
            size_next = brsc_pkg::SZ_SMALL;
        else
            size_next = brsc_pkg::SZ_NORMAL;
    end

    assign res.valid          = res_valid_reg;
    assign res.relation_class = rel_reg;
    assign res.size_class     = size_reg;

`ifndef NO_ASSERTIONS
    // a request held in stage 1 must reach the result register when it frees up
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_accept) |=> res_valid_reg)
        else $error("stage 1 request lost on advance");

    // a new request may only enter a full stage 1 when that stage drains
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (obj.valid && obj.ready && s1_valid_reg) |-> s2_accept)
        else $error("stage 1 overwritten");

    // stalled output keeps stage 1 valid, x center and x half-extent too
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready && s1_valid_reg) |=>
            (s1_valid_reg && $stable(s1_cx_reg) && $stable(s1_hx_reg)))
        else $error("stage 1 changed during stall");

    // huge always means the x half-extent exceeds the reference
    a_huge_x: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && size_next == brsc_pkg::SZ_HUGE) |-> (s1_hx_reg > ref_hx_reg))
        else $error("huge class with small x extent");
`endif

endmodule

`default_nettype wire
